FILE: rtl/mt_pkg.sv
// ----------------------------------------------------------------------------
// mt_pkg
// Shared constants, types and word functions of the twister generator.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int unsigned TABLE_WORDS = 624;
  localparam int unsigned SHIFT_WORDS = 397;
  localparam int unsigned CNT_W       = $clog2(TABLE_WORDS);

  localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(TABLE_WORDS - 1);

  localparam logic [31:0] SEED_MULT  = 32'h6c07_8965;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  localparam logic CFG_ADDR_SEED = 1'b0;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load;
    logic step;
  } seed_ctl_t;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t mag;
    y   = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    mag = y[0] ? MATRIX_A : 32'd0;
    return far ^ (y >> 1) ^ mag;
  endfunction

  function automatic word_t temper_word(word_t x_in);
    word_t x;
    x = x_in;
    x = x ^ (x >> 11);
    x = x ^ ((x << 7) & TEMPER_B);
    x = x ^ ((x << 15) & TEMPER_C);
    x = x ^ (x >> 18);
    return x;
  endfunction

endpackage

FILE: rtl/mt_if.sv
// ----------------------------------------------------------------------------
// mt_if
// Valid/ready channels for requests and generated words.
// ----------------------------------------------------------------------------
interface mt_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/mt_cell.sv
// ----------------------------------------------------------------------------
// mt_cell
// One word of the state ring; loads its d_in word (its neighbor's, or the new word at the tail) when the ring shifts.
// ----------------------------------------------------------------------------
module mt_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  mt_pkg::word_t d_in,
  output mt_pkg::word_t q
);
  import mt_pkg::*;

  word_t word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;

endmodule

FILE: rtl/mt_seed_gen.sv
// ----------------------------------------------------------------------------
// mt_seed_gen
// Seed recurrence: one multiply per cycle while ctl.step is set, product registered.
// ----------------------------------------------------------------------------
module mt_seed_gen (
  input  logic              clk,
  input  mt_pkg::seed_ctl_t ctl,
  input  mt_pkg::word_t     seed,
  output mt_pkg::word_t     word
);
  import mt_pkg::*;

  word_t w_r;
  word_t w_nxt;

  always_comb begin
    priority if (ctl.load) begin
      w_nxt = seed;
    end else if (ctl.step) begin
      w_nxt = SEED_MULT * (w_r ^ (w_r >> 30));
    end else begin
      w_nxt = w_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  assign word = w_r;

endmodule

FILE: rtl/mt_twist.sv
// ----------------------------------------------------------------------------
// mt_twist
// Next ring word from the head taps, and its tempered form.
// ----------------------------------------------------------------------------
module mt_twist (
  input  mt_pkg::word_t cur,
  input  mt_pkg::word_t nxt,
  input  mt_pkg::word_t far,
  output mt_pkg::word_t new_word,
  output mt_pkg::word_t tempered
);
  import mt_pkg::*;

  assign new_word = twist_word(cur, nxt, far);
  assign tempered = temper_word(new_word);

endmodule

FILE: rtl/mersenne_twister_prng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_prng
// 32-bit twister generator built as a ring of 624 word cells.
//
// Usage: each transaction on in_ch requests one word; out_ch returns one
// tempered 32-bit word per request, in order. The seed register sits at
// address 0 of the cfg_ port and is taken at the next seeding.
// A request with restart set, and the first request after reset, refill
// the ring from the seed: the seed multiplier shifts 624 words into the
// ring, then the twist state twists and emits word 0 once the output is
// free. Refill time is set by the single multiplier and the ring length.
// Other requests are served directly: the word is twisted from the ring head
// taps, shifted in at the tail and registered at the output, so one
// request per cycle is sustained while out_ch.ready stays high; out_ch.valid
// rises in the cycle after accept.
// Reset clears control state and the seed register to 5489; the ring
// contents are undefined until the first seeding.
// When the receiver stalls, the output register holds its word and
// in_ch.ready drops until the word is taken.
// ----------------------------------------------------------------------------
module mersenne_twister_prng (
  input  logic        clk,
  input  logic        rst_n,
  mt_in_if.sink       in_ch,
  mt_out_if.source    out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mt_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_TWIST = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             seeded_r, seeded_nxt;
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;
  word_t            seed_r;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_value_r, out_value_nxt;

  word_t     ring_q [TABLE_WORDS];
  word_t     tail_word;
  logic      shift_en;
  word_t     seed_word;
  word_t     new_word;
  word_t     tempered;
  seed_ctl_t seed_ctl;
  logic      out_free;
  logic      accept;
  logic      need_seed;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  // state ring
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_WORDS; gi++) begin : g_ring
      if (gi == TABLE_WORDS - 1) begin : g_tail
        mt_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d_in     (tail_word),
          .q        (ring_q[gi])
        );
      end else begin : g_body
        mt_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d_in     (ring_q[gi+1]),
          .q        (ring_q[gi])
        );
      end
    end
  endgenerate

  mt_seed_gen u_seed_gen (
    .clk  (clk),
    .ctl  (seed_ctl),
    .seed (seed_r),
    .word (seed_word)
  );

  mt_twist u_twist (
    .cur      (ring_q[0]),
    .nxt      (ring_q[1]),
    .far      (ring_q[SHIFT_WORDS]),
    .new_word (new_word),
    .tempered (tempered)
  );

  // control
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_RUN) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign need_seed    = in_ch.restart || !seeded_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    fill_cnt_nxt  = fill_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    shift_en      = 1'b0;
    tail_word     = new_word;
    seed_ctl      = '0;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (need_seed) begin
            seed_ctl.load = 1'b1;
            fill_cnt_nxt  = '0;
            state_nxt     = ST_FILL;
          end else begin
            shift_en      = 1'b1;
            out_valid_nxt = 1'b1;
            out_value_nxt = tempered;
          end
        end
      end
      ST_FILL: begin
        shift_en      = 1'b1;
        tail_word     = seed_word;
        seed_ctl.step = 1'b1;
        fill_cnt_nxt  = fill_cnt_r + 1'b1;
        if (fill_cnt_r == FILL_LAST) begin
          seeded_nxt = 1'b1;
          state_nxt  = ST_TWIST;
        end
      end
      ST_TWIST: begin
        if (out_free) begin
          shift_en      = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = tempered;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      seeded_r    <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && fill_cnt_r == FILL_LAST) |=> (state_r == ST_TWIST))
    else $error("fill did not hand over to twist");

  a_seed_request: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && need_seed) |=> (state_r == ST_FILL && !out_valid_r || state_r == ST_FILL))
    else $error("seeding request did not start a fill");

  a_twist_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TWIST) |-> seeded_r)
    else $error("twist state reached without seeding");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(accept) && !$past(need_seed)) || ($past(state_r) == ST_TWIST))
    else $error("output word appeared without a request");

endmodule
